// File: design/sactr_pkg.sv
// Shared types and constants for the set-associative cache tag store.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sactr_pkg;

	localparam int NUM_SETS_DEF = 64;
	localparam int NUM_WAYS_DEF = 8;
	localparam int TAG_BITS_DEF = 20;

	localparam int SET_IN_W  = 6;
	localparam int TAG_IN_W  = 20;
	localparam int WAY_OUT_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int POL_W     = 2;
	localparam int WAYS_CFG_W = 4;

	localparam int CNT_BITS = 16;
	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

	localparam int LFSR_W = 16;
	localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
	localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 4'd8;
	localparam int MOD_DIGIT = 4;
	localparam int MOD_STEPS = LFSR_W / MOD_DIGIT;
	localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

	localparam logic [POL_W-1:0] POL_LRU  = 2'd0;
	localparam logic [POL_W-1:0] POL_LFU  = 2'd1;
	localparam logic [POL_W-1:0] POL_RAND = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_MOD,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic capture;
		logic look;
		logic rand_start;
		logic mod_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_rand;
		logic out_full;
	} sts_t;

	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] x);
		logic b;
		b = x[0] ^ x[2] ^ x[3] ^ x[5];
		return {b, x[LFSR_W-1:1]};
	endfunction

endpackage
`default_nettype wire

// File: design/set_assoc_cache_tag_replace.sv
// Top level of the set-associative cache tag store with selectable replacement.
// Depends on sactr_pkg, sactr_ctrl, sactr_dp and sactr_ram.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block clears the set memory, one row per cycle, and accepts
// no word until that pass ends. Each access then accepts and reads the set row,
// ages and searches the ways, and writes the row back and loads the result
// register; the write waits while the output register holds an unaccepted result.
// A random replacement adds, before the write, a reduction of the LFSR word
// modulo the way count, one hex digit at a time. The next word is accepted while
// a finished result still waits in the output register.
module set_assoc_cache_tag_replace #(
	parameter int NUM_SETS = sactr_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = sactr_pkg::NUM_WAYS_DEF,
	parameter int TAG_BITS = sactr_pkg::TAG_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sactr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sactr_pkg::CFG_DAT_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [sactr_pkg::SET_IN_W-1:0]  set_index,
	input  wire logic [sactr_pkg::TAG_IN_W-1:0]  tag,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 hit,
	output logic      [sactr_pkg::WAY_OUT_W-1:0] way,
	output logic                                 evicted
);
	import sactr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sactr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sactr_dp #(
		.NUM_SETS(NUM_SETS),
		.NUM_WAYS(NUM_WAYS),
		.TAG_BITS(TAG_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.set_index(set_index),
		.tag      (tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit      (hit),
		.way      (way),
		.evicted  (evicted),
		.cmd      (cmd),
		.sts      (sts)
	);
endmodule
`default_nettype wire

// File: design/sactr_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Holds the per-set rows of the tag store; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sactr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: design/sactr_ctrl.sv
// Controller state machine: clearing pass, lookup, random victim reduction and commit.
// Depends on sactr_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module sactr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sactr_pkg::sts_t sts,
	output sactr_pkg::cmd_t      cmd
);
	import sactr_pkg::*;

	state_t state_q, state_d;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic mod_last;

	assign mod_last = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			mod_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MOD) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
			end else begin
				mod_cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = sts.need_rand ? ST_MOD : ST_WRITE;
			end
			ST_MOD: begin
				if (mod_last) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!sts.out_full) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_LOOK: begin
				cmd.look       = 1'b1;
				cmd.rand_start = sts.need_rand;
			end
			ST_MOD: cmd.mod_step = 1'b1;
			ST_WRITE: cmd.commit = !sts.out_full;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// File: design/sactr_dp.sv
// Datapath: configuration registers, set row memory, aging, hit and victim search,
// LFSR with its modulo reduction, and the result register. Depends on sactr_pkg and sactr_ram.
`timescale 1ns / 1ps
`default_nettype none
module sactr_dp #(
	parameter int NUM_SETS = 64,
	parameter int NUM_WAYS = 8,
	parameter int TAG_BITS = 20
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [sactr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sactr_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  wire logic [sactr_pkg::SET_IN_W-1:0]       set_index,
	input  wire logic [sactr_pkg::TAG_IN_W-1:0]       tag,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      hit,
	output logic      [sactr_pkg::WAY_OUT_W-1:0]      way,
	output logic                                      evicted,
	input  wire sactr_pkg::cmd_t                      cmd,
	output sactr_pkg::sts_t                           sts
);
	import sactr_pkg::*;

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int NW_W  = $clog2(NUM_WAYS + 1);
	localparam int ROW_W = NUM_WAYS * (1 + 2 * CNT_BITS + TAG_BITS);
	localparam int SET_TAB_N = 2 ** SET_IN_W;

	logic [POL_W-1:0]      policy_q;
	logic [WAYS_CFG_W-1:0] ways_q;
	logic [LFSR_W-1:0]     lfsr_q;
	logic [NW_W-1:0]       n_eff;
	logic [NUM_WAYS-1:0]   in_use;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_LRU;
			ways_q   <= WAYS_RESET;
			lfsr_q   <= SEED_RESET;
		end else begin
			if (cfg_we && cfg_index == CFG_POLICY) policy_q <= cfg_data[POL_W-1:0];
			if (cfg_we && cfg_index == CFG_WAYS) ways_q <= cfg_data[WAYS_CFG_W-1:0];
			if (cfg_we && cfg_index == CFG_SEED) begin
				lfsr_q <= cfg_data[LFSR_W-1:0];
			end else if (cmd.rand_start) begin
				lfsr_q <= lfsr_next(lfsr_q);
			end
		end
	end

	always_comb begin
		if (ways_q == '0) begin
			n_eff = NW_W'(1);
		end else if (32'(ways_q) > NUM_WAYS) begin
			n_eff = NW_W'(NUM_WAYS);
		end else begin
			n_eff = NW_W'(ways_q);
		end
		for (int i = 0; i < NUM_WAYS; i++) begin
			in_use[i] = (NW_W'(i) < n_eff);
		end
	end

	// Set index reduction is a constant table, so any set count works.
	logic [SET_W-1:0] set_tab [SET_TAB_N];
	for (genvar g = 0; g < SET_TAB_N; g++) begin : g_set_tab
		assign set_tab[g] = SET_W'(g % NUM_SETS);
	end

	logic [SET_W-1:0]    set_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [SET_W-1:0]    clr_cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			set_q <= set_tab[set_index];
			tag_q <= TAG_BITS'(tag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_cnt_q == SET_W'(NUM_SETS - 1));

	logic                 ram_we;
	logic [SET_W-1:0]     ram_waddr;
	logic [ROW_W-1:0]     ram_wdata, ram_rdata, new_row;

	assign ram_we    = cmd.clr_step | cmd.commit;
	assign ram_waddr = cmd.clr_step ? clr_cnt_q : set_q;
	assign ram_wdata = cmd.clr_step ? '0 : new_row;

	sactr_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.capture),
		.raddr(set_tab[set_index]),
		.rdata(ram_rdata)
	);

	logic [NUM_WAYS-1:0]                rv;
	logic [NUM_WAYS-1:0][CNT_BITS-1:0]  ra, ru;
	logic [NUM_WAYS-1:0][TAG_BITS-1:0]  rt;
	logic [NUM_WAYS-1:0][CNT_BITS-1:0]  aged;
	logic             lk_hit, lk_inv;
	logic [WAY_W-1:0] lk_hit_way, lk_inv_way, lk_lru, lk_lfu;

	assign {rv, ra, ru, rt} = ram_rdata;

	always_comb begin
		lk_hit     = 1'b0;
		lk_inv     = 1'b0;
		lk_hit_way = '0;
		lk_inv_way = '0;
		lk_lru     = '0;
		lk_lfu     = '0;
		for (int i = 0; i < NUM_WAYS; i++) begin
			aged[i] = (rv[i] && in_use[i]) ? sat_inc(ra[i]) : ra[i];
		end
		for (int i = NUM_WAYS - 1; i >= 0; i--) begin
			if (in_use[i] && rv[i] && rt[i] == tag_q) begin
				lk_hit     = 1'b1;
				lk_hit_way = WAY_W'(i);
			end
			if (in_use[i] && !rv[i]) begin
				lk_inv     = 1'b1;
				lk_inv_way = WAY_W'(i);
			end
		end
		for (int i = 1; i < NUM_WAYS; i++) begin
			if (in_use[i] && aged[i] > aged[lk_lru]) lk_lru = WAY_W'(i);
			if (in_use[i] && ru[i] < ru[lk_lfu]) lk_lfu = WAY_W'(i);
		end
	end

	assign sts.need_rand = !lk_hit && !lk_inv && (policy_q == POL_RAND);

	logic [NUM_WAYS-1:0]               v_q;
	logic [NUM_WAYS-1:0][CNT_BITS-1:0] a_q, u_q;
	logic [NUM_WAYS-1:0][TAG_BITS-1:0] t_q;
	logic             hit_q, inv_q;
	logic [WAY_W-1:0] hit_way_q, inv_way_q, lru_q, lfu_q;

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			v_q       <= rv;
			a_q       <= aged;
			u_q       <= ru;
			t_q       <= rt;
			hit_q     <= lk_hit;
			inv_q     <= lk_inv;
			hit_way_q <= lk_hit_way;
			inv_way_q <= lk_inv_way;
			lru_q     <= lk_lru;
			lfu_q     <= lk_lfu;
		end
	end

	// Random victim: the stepped LFSR word is reduced modulo the way count,
	// one hex digit per cycle, most significant first.
	logic [LFSR_W-1:0] mod_x_q;
	logic [NW_W-1:0]   mod_r_q, mod_r_d;
	logic [NW_W:0]     mod_t;

	always_comb begin
		mod_r_d = mod_r_q;
		mod_t   = '0;
		for (int k = 0; k < MOD_DIGIT; k++) begin
			mod_t = {mod_r_d, mod_x_q[LFSR_W-1-k]};
			if (mod_t >= {1'b0, n_eff}) mod_t = mod_t - {1'b0, n_eff};
			mod_r_d = mod_t[NW_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rand_start) begin
			mod_x_q <= lfsr_next(lfsr_q);
			mod_r_q <= '0;
		end else if (cmd.mod_step) begin
			mod_x_q <= mod_x_q << MOD_DIGIT;
			mod_r_q <= mod_r_d;
		end
	end

	logic             do_fill, do_evict;
	logic [WAY_W-1:0] sel;

	always_comb begin
		do_fill  = 1'b0;
		do_evict = 1'b0;
		sel      = '0;
		if (hit_q) begin
			sel = hit_way_q;
		end else if (inv_q) begin
			do_fill = 1'b1;
			sel     = inv_way_q;
		end else begin
			case (policy_q)
				POL_LRU: begin
					do_evict = 1'b1;
					sel      = lru_q;
				end
				POL_LFU: begin
					do_evict = 1'b1;
					sel      = lfu_q;
				end
				POL_RAND: begin
					do_evict = 1'b1;
					sel      = WAY_W'(mod_r_q);
				end
				default: sel = '0;
			endcase
			do_fill = do_evict;
		end
	end

	logic [NUM_WAYS-1:0]               nv;
	logic [NUM_WAYS-1:0][CNT_BITS-1:0] na, nu;
	logic [NUM_WAYS-1:0][TAG_BITS-1:0] nt;

	always_comb begin
		nv = v_q;
		na = a_q;
		nu = u_q;
		nt = t_q;
		for (int i = 0; i < NUM_WAYS; i++) begin
			if ((hit_q || do_fill) && sel == WAY_W'(i)) begin
				na[i] = '0;
				nu[i] = sat_inc(u_q[i]);
				if (do_fill) begin
					nv[i] = 1'b1;
					nt[i] = tag_q;
				end
			end
		end
	end

	assign new_row = {nv, na, nu, nt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit     <= hit_q;
			way     <= WAY_OUT_W'(sel);
			evicted <= do_evict;
		end
	end

	assign sts.out_full = out_valid & ~out_ready;
endmodule
`default_nettype wire

// File: sim/cache_tag_checker.sv
// Checker for the set-associative cache tag store: mirrors the tag, valid, age and
// use-count state, predicts each result word and compares it. Depends on sactr_pkg.
`timescale 1ns / 1ps
module cache_tag_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sactr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sactr_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [sactr_pkg::SET_IN_W-1:0]   set_index,
	input  logic [sactr_pkg::TAG_IN_W-1:0]   tag,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic                             hit,
	input  logic [sactr_pkg::WAY_OUT_W-1:0]  way,
	input  logic                             evicted,
	output int                               fail_count,
	output int                               pending
);
	import sactr_pkg::*;

	localparam int SETS = NUM_SETS_DEF;
	localparam int WAYS = NUM_WAYS_DEF;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic                 evicted;
	} lookup_t;

	logic [TAG_IN_W-1:0] m_tag [SETS][WAYS];
	logic                m_valid [SETS][WAYS];
	logic [CNT_BITS-1:0] m_age [SETS][WAYS];
	logic [CNT_BITS-1:0] m_use [SETS][WAYS];
	logic [LFSR_W-1:0]   m_lfsr;
	logic [POL_W-1:0]    m_policy;
	logic [WAYS_CFG_W-1:0] m_ways;
	lookup_t             lookup_q[$];

	function automatic logic [CNT_BITS-1:0] bump(input logic [CNT_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic lookup_t access_set(input int s, input logic [TAG_IN_W-1:0] t);
		lookup_t r;
		int n;
		int v;
		bit done;
		r = '0;
		done = 0;
		v = 0;
		n = (m_ways < 1) ? 1 : ((m_ways > WAYS) ? WAYS : int'(m_ways));
		for (int i = 0; i < n; i++)
			if (m_valid[s][i]) m_age[s][i] = bump(m_age[s][i]);
		for (int i = 0; i < n && !done; i++)
			if (m_valid[s][i] && m_tag[s][i] == t) begin
				m_age[s][i] = 0;
				m_use[s][i] = bump(m_use[s][i]);
				r.hit = 1;
				r.way = i[WAY_OUT_W-1:0];
				done = 1;
			end
		for (int i = 0; i < n && !done; i++)
			if (!m_valid[s][i]) begin
				v = i;
				done = 1;
				r.way = i[WAY_OUT_W-1:0];
			end
		if (!done && m_policy <= POL_RAND) begin
			if (m_policy == POL_LRU) begin
				for (int i = 1; i < n; i++)
					if (m_age[s][i] > m_age[s][v]) v = i;
			end else if (m_policy == POL_LFU) begin
				for (int i = 1; i < n; i++)
					if (m_use[s][i] < m_use[s][v]) v = i;
			end else begin
				m_lfsr = {m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5], m_lfsr[LFSR_W-1:1]};
				v = int'(m_lfsr) % n;
			end
			r.way = v[WAY_OUT_W-1:0];
			r.evicted = 1;
			done = 1;
		end else if (!done) begin
			return r;
		end
		if (!r.hit) begin
			m_tag[s][v] = t;
			m_valid[s][v] = 1;
			m_age[s][v] = 0;
			m_use[s][v] = bump(m_use[s][v]);
		end
		return r;
	endfunction

	assign pending = lookup_q.size();

	always @(posedge clk or negedge arst_n) begin
		lookup_t exp_r;
		if (!arst_n) begin
			fail_count <= 0;
			lookup_q.delete();
			m_policy = POL_LRU;
			m_ways = WAYS_RESET;
			m_lfsr = SEED_RESET;
			for (int s = 0; s < SETS; s++)
				for (int w = 0; w < WAYS; w++) begin
					m_tag[s][w] = '0;
					m_valid[s][w] = 0;
					m_age[s][w] = '0;
					m_use[s][w] = '0;
				end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_POLICY: m_policy = cfg_data[POL_W-1:0];
					CFG_WAYS: m_ways = cfg_data[WAYS_CFG_W-1:0];
					CFG_SEED: m_lfsr = cfg_data[LFSR_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				lookup_q.push_back(access_set(int'(set_index) % SETS, tag));
			if (out_valid && out_ready) begin
				if (lookup_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: hit %0d way %0d evicted %0d",
							hit, way, evicted);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = lookup_q.pop_front();
					if (exp_r != {hit, way, evicted}) begin
						if (fail_count < 10)
							$display("mismatch: expected hit %0d way %0d evicted %0d, got %0d %0d %0d",
								exp_r.hit, exp_r.way, exp_r.evicted, hit, way, evicted);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: sim/testbench.sv
// Top of the cache tag store testbench: clock, reset, configuration phases,
// access stimulus with random gaps and the verdict. Depends on sactr_pkg and the checker.
`timescale 1ns / 1ps
module testbench;
	import sactr_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [SET_IN_W-1:0] set_index = '0;
	logic [TAG_IN_W-1:0] tag = '0;
	logic out_valid;
	logic out_ready = 0;
	logic hit;
	logic [WAY_OUT_W-1:0] way;
	logic evicted;
	int fail_count;
	int pending;
	int send_idle = 31;
	int recv_idle = 60;
	bit hold_recv = 0;
	int cycles = 0;
	logic [TAG_IN_W-1:0] tag_pool [8];

	set_assoc_cache_tag_replace u_top (.*);

	cache_tag_checker u_chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_recv) out_ready <= 0;
		else out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_access(input logic [SET_IN_W-1:0] s, input logic [TAG_IN_W-1:0] t);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		set_index <= s;
		tag <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_accesses(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 7)
				send_access(SET_IN_W'($urandom_range(3)),
					tag_pool[$urandom_range(7)]);
			else
				send_access(SET_IN_W'($urandom), TAG_IN_W'($urandom));
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) tag_pool[i] = TAG_IN_W'($urandom);
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		repeat (11) @(negedge clk);
		arst_n <= 1;
		// Directed: fill one set, hit, then evict under each policy and extreme ways.
		for (int i = 0; i < 9; i++) send_access(6'd63, i[TAG_IN_W-1:0] + 20'hFFFF0);
		send_access(6'd63, 20'hFFFF3);
		send_access(6'd0, '0);
		send_access(6'd0, '1);
		write_reg(CFG_POLICY, CFG_DAT_W'(POL_LFU));
		send_access(6'd63, 20'h12345);
		write_reg(CFG_POLICY, CFG_DAT_W'(POL_RAND));
		write_reg(CFG_SEED, 16'hFFFF);
		for (int i = 0; i < 3; i++) send_access(6'd63, TAG_IN_W'(20'h55555 + i));
		write_reg(CFG_SEED, 16'h0000);
		send_access(6'd63, 20'hAAAAA);
		write_reg(CFG_POLICY, CFG_DAT_W'(2'd3));
		send_access(6'd63, 20'h0F0F0);
		write_reg(CFG_WAYS, CFG_DAT_W'(4'd0));
		send_access(6'd63, 20'h00001);
		write_reg(CFG_WAYS, CFG_DAT_W'(4'd15));
		send_access(6'd63, 20'h00002);
		// Random phases over several settings.
		write_reg(CFG_POLICY, CFG_DAT_W'(POL_LRU));
		write_reg(CFG_WAYS, CFG_DAT_W'(4'd4));
		random_accesses(300);
		// Long receiver hold while the sender keeps going.
		hold_recv = 1;
		fork
			random_accesses(20);
			begin
				repeat (300) @(negedge clk);
				hold_recv = 0;
			end
		join
		write_reg(CFG_POLICY, CFG_DAT_W'(POL_LFU));
		write_reg(CFG_WAYS, CFG_DAT_W'(4'd8));
		send_idle = 60;
		recv_idle = 31;
		random_accesses(400);
		write_reg(CFG_POLICY, CFG_DAT_W'(POL_RAND));
		write_reg(CFG_SEED, CFG_DAT_W'($urandom_range(65535, 1)));
		write_reg(CFG_WAYS, CFG_DAT_W'(4'd1));
		random_accesses(150);
		write_reg(CFG_WAYS, CFG_DAT_W'(4'd5));
		random_accesses(300);
		send_idle = 0;
		recv_idle = 0;
		write_reg(CFG_POLICY, CFG_DAT_W'(POL_LRU));
		random_accesses(300);
		write_reg(CFG_POLICY, CFG_DAT_W'(POL_RAND));
		write_reg(CFG_WAYS, CFG_DAT_W'(4'd8));
		random_accesses(350);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
